### rtl/dkp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dkp_pkg - shared types and codes for the dual-key pin lookup table
// Request and status codes, field widths, the stored entry layout and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dkp_pkg;

    localparam int REQ_W  = 2;
    localparam int KEY_W  = 32;
    localparam int GPIO_W = 10;
    localparam int STAT_W = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BALL   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]  net_key;
        logic [KEY_W-1:0]  ball_key;
        logic [GPIO_W-1:0] gpio;
    } dkp_entry_t;

    typedef struct packed {
        logic start;   // load request word, clear scan state
        logic step;    // read next entry
        logic finish;  // load result, commit insert
    } dkp_cmd_t;

    typedef struct packed {
        logic empty;   // no entries filled
        logic last;    // current read is the last filled entry
    } dkp_sts_t;

endpackage
`default_nettype wire

### rtl/dkp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dkp_req_if - request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface dkp_req_if
    import dkp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]  net_key;
    logic [KEY_W-1:0]  ball_key;
    logic [GPIO_W-1:0] gpio_in;

    modport source (output valid, req_type, net_key, ball_key, gpio_in, input ready);
    modport sink   (input valid, req_type, net_key, ball_key, gpio_in, output ready);
endinterface
`default_nettype wire

### rtl/dkp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dkp_rsp_if - response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface dkp_rsp_if
    import dkp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [GPIO_W-1:0] gpio_out;

    modport source (output valid, status, gpio_out, input ready);
    modport sink   (input valid, status, gpio_out, output ready);
endinterface
`default_nettype wire

### rtl/dkp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dkp_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dkp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

### rtl/dkp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dkp_ctrl - request sequencer
// Accepts a request, walks the filled entries, waits for the last compare
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module dkp_ctrl
    import dkp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dkp_sts_t sts,
    output dkp_cmd_t cmd
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.empty ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read word is compared this cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
endmodule
`default_nettype wire

### rtl/dkp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dkp_dp - table datapath
// Entry RAM, fill count, scan address, key compare and result register.
// Slots fill in order and are never freed, so slot i is valid iff i < count.
// ----------------------------------------------------------------------------
module dkp_dp
    import dkp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dkp_cmd_t          cmd,
    output dkp_sts_t          sts,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [KEY_W-1:0]  net_key,
    input  logic [KEY_W-1:0]  ball_key,
    input  logic [GPIO_W-1:0] gpio_in,
    output logic [STAT_W-1:0] status,
    output logic [GPIO_W-1:0] gpio_out
);
    localparam int IDXW  = $clog2(TABLE_ENTRIES);
    localparam int CNTW  = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = $bits(dkp_entry_t);

    // request word
    logic [REQ_W-1:0]  type_reg;
    logic [KEY_W-1:0]  net_reg;
    logic [KEY_W-1:0]  ball_reg;
    logic [GPIO_W-1:0] gpio_reg;

    logic [CNTW-1:0]   count_reg, count_next;
    logic [IDXW-1:0]   idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    logic [GPIO_W-1:0] hit_gpio_reg;
    logic [STAT_W-1:0] status_reg;
    logic [GPIO_W-1:0] gpio_out_reg;

    logic [ENT_W-1:0]  rd_data;
    dkp_entry_t        rd_entry;
    dkp_entry_t        wr_entry;
    logic              key_hit;
    logic              full;
    logic              is_insert;
    logic              ins_ok;
    logic [STAT_W-1:0] res_status;
    logic [GPIO_W-1:0] res_gpio;

    assign rd_entry = dkp_entry_t'(rd_data);
    assign wr_entry = '{net_key: net_reg, ball_key: ball_reg, gpio: gpio_reg};

    dkp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.finish && ins_ok),
        .wr_addr (count_reg[IDXW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (cmd.step),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign sts.empty = (count_reg == '0);
    assign sts.last  = ((CNTW'(idx_reg) + CNTW'(1)) == count_reg);

    always_comb
    begin
        unique case (type_reg)
            REQ_INSERT: key_hit = (rd_entry.net_key == net_reg) ||
                                  (rd_entry.ball_key == ball_reg);
            REQ_NET:    key_hit = (rd_entry.net_key == net_reg);
            REQ_BALL:   key_hit = (rd_entry.ball_key == ball_reg);
            default:    key_hit = 1'b0;
        endcase
    end

    assign full      = (count_reg == CNTW'(TABLE_ENTRIES));
    assign is_insert = (type_reg == REQ_INSERT);
    assign ins_ok    = is_insert && !hit_reg && !full;

    // duplicate check wins over table full
    always_comb
    begin
        priority if (is_insert && hit_reg)
        begin
            res_status = ST_DUPLICATE;
        end
        else if (is_insert && full)
        begin
            res_status = ST_FULL;
        end
        else if (is_insert)
        begin
            res_status = ST_INSERTED;
        end
        else if (hit_reg)
        begin
            res_status = ST_FOUND;
        end
        else
        begin
            res_status = ST_NOT_FOUND;
        end
    end

    assign res_gpio = (!is_insert && hit_reg) ? hit_gpio_reg : '0;

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        pend_next  = cmd.step;
        if (cmd.start)
        begin
            idx_next = '0;
            hit_next = 1'b0;
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg + IDXW'(1);
        end
        if (pend_reg && key_hit)
        begin
            hit_next = 1'b1;
        end
        if (cmd.finish && ins_ok)
        begin
            count_next = count_reg + CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            type_reg <= req_type;
            net_reg  <= net_key;
            ball_reg <= ball_key;
            gpio_reg <= gpio_in;
        end
        // keep the lowest-indexed match
        if (pend_reg && key_hit && !hit_reg)
        begin
            hit_gpio_reg <= rd_entry.gpio;
        end
        if (cmd.finish)
        begin
            status_reg   <= res_status;
            gpio_out_reg <= res_gpio;
        end
    end

    assign status   = status_reg;
    assign gpio_out = gpio_out_reg;
endmodule
`default_nettype wire

### rtl/dual_key_pin_lookup_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_key_pin_lookup_table - pin table keyed by net and by ball
// Insert with duplicate check on both keys, lookup by either key.
//
//   channel  dir  fields
//   req      in   req_type, net_key, ball_key, gpio_in
//   rsp      out  status, gpio_out
//
// After accept, the scan state reads the filled entries one per cycle from the
// entry RAM, the drain state compares the last one and the done state loads the
// result; on an empty table the request goes straight to the done state.
// Reset clears the fill count; the RAM contents need no clearing.
// The result sits in an output register; a new request is taken while it
// waits, and a finished request holds until that register frees up.
// ----------------------------------------------------------------------------
module dual_key_pin_lookup_table
    import dkp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    dkp_req_if.sink   req,
    dkp_rsp_if.source rsp
);
    dkp_cmd_t cmd;
    dkp_sts_t sts;

    dkp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dkp_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req_type (req.req_type),
        .net_key  (req.net_key),
        .ball_key (req.ball_key),
        .gpio_in  (req.gpio_in),
        .status   (rsp.status),
        .gpio_out (rsp.gpio_out)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !req.ready)
        else $error("request channel still ready after accept");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp.valid)
        else $error("finished request did not show a result");

    a_no_scan_empty: assert property (@(posedge clk) disable iff (!rst_n)
        sts.empty |-> !cmd.step)
        else $error("scan issued on an empty table");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.step, cmd.finish}))
        else $error("overlapping datapath commands");
endmodule
`default_nettype wire
